FILE: rtl/tsp_edu_pkg.sv
// Package with the shared widths and constants of the TSP edge distance unit.
package tsp_edu_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int OUT_BITS       = 16;
    localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

    typedef enum logic {
        METRIC_EUC = 1'b0,
        METRIC_ATT = 1'b1
    } t_metric;

endpackage

FILE: rtl/tsp_edge_distance_unit.sv
// Pipelined TSP edge length unit with Euclidean rounded and ATT ceiling metrics.
//
// One request is accepted per cycle while o_stall is low. The depth comes from the
// integer square root, which settles one root bit per stage after the difference,
// squaring and sum stages. The metric register is written through i_cfg_wr_en and
// i_cfg_wr_data, by the user only while no request is in flight; the block does not
// enforce this. A two-entry output register and skid buffer keep the pipeline moving
// while a finished length waits to be taken; o_stall rises only when both are full.
module tsp_edge_distance_unit
    import tsp_edu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-1:0] i_second_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_BITS-1:0]   o_edge_length
);

    localparam int SQ_W = 2 * COORD_BITS;
    localparam int SW   = 2 * COORD_BITS + 1;
    localparam int TW   = SW + 5;
    localparam int RW   = COORD_BITS + 1;
    localparam int XW   = (RW + 1 > OUT_BITS + 1) ? RW + 1 : OUT_BITS + 1;
    localparam int NS   = COORD_BITS + 2;
    localparam int NP   = COORD_BITS + 4;

    t_metric                 r_metric;
    logic [NP-1:0]           r_v;
    logic                    w_en;
    logic [COORD_BITS-1:0]   r_dx;
    logic [COORD_BITS-1:0]   r_dy;
    logic [SQ_W-1:0]         r_sqx;
    logic [SQ_W-1:0]         r_sqy;
    logic [SW-1:0]           r_rem  [0:NS-1];
    logic [RW-1:0]           r_root [0:NS-1];

    logic                    w_up;
    logic [XW-1:0]           w_res;
    logic [OUT_BITS-1:0]     w_len;

    logic                    r_ov;
    logic [OUT_BITS-1:0]     r_out;
    logic                    r_sv;
    logic [OUT_BITS-1:0]     r_skid;

    assign w_en    = !r_sv;
    assign o_stall = r_sv;
    assign o_valid = r_ov;
    assign o_edge_length = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_EUC;
        end else if (i_cfg_wr_en) begin
            r_metric <= t_metric'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NP-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx   <= (i_first_x >= i_second_x) ? i_first_x - i_second_x
                                                : i_second_x - i_first_x;
            r_dy   <= (i_first_y >= i_second_y) ? i_first_y - i_second_y
                                                : i_second_y - i_first_y;
            r_sqx  <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sqy  <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_rem[0]  <= SW'(r_sqx) + SW'(r_sqy);
            r_root[0] <= '0;
        end
    end

    // Each stage tries the next lower root bit against the remainder, scaled by ten
    // in ATT mode so that the root becomes the largest t with 10*t*t not above the sum.
    for (genvar g = 0; g < NS - 1; g++) begin : g_sqrt
        localparam int B = COORD_BITS - g;
        logic [TW-1:0] w_base;
        logic [TW-1:0] w_trial;
        logic          w_ge;

        always_comb begin
            w_base  = (TW'(r_root[g]) << (B + 1)) | (TW'(1) << (2 * B));
            w_trial = (r_metric == METRIC_ATT) ? (w_base << 3) + (w_base << 1) : w_base;
            w_ge    = TW'(r_rem[g]) >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[g+1]  <= w_ge ? r_rem[g] - w_trial[SW-1:0] : r_rem[g];
                r_root[g+1] <= w_ge ? r_root[g] | (RW'(1) << B) : r_root[g];
            end
        end
    end

    always_comb begin
        if (r_metric == METRIC_ATT) begin
            w_up = r_rem[NS-1] != '0;
        end else begin
            w_up = r_rem[NS-1] > SW'(r_root[NS-1]);
        end
        w_res = XW'(r_root[NS-1]) + XW'(w_up);
        w_len = (w_res > XW'(OUT_MAX)) ? OUT_MAX : w_res[OUT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            r_ov <= r_sv || r_v[NP-1];
            r_sv <= 1'b0;
        end else if (w_en && r_v[NP-1]) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_out <= r_sv ? r_skid : w_len;
        end else if (w_en && r_v[NP-1]) begin
            r_skid <= w_len;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v[0])
        else $error("Accepted request did not enter the first stage.");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("Skid buffer holds a result while the output register is empty.");

    a_skid_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && i_stall |=> r_sv && $stable(r_skid))
        else $error("Skid buffer changed while the output was stalled.");

    a_euc_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NP-1] && r_metric == METRIC_EUC
            |-> r_rem[NS-1] <= SW'({r_root[NS-1], 1'b0}))
        else $error("Square root remainder exceeds twice the root.");
`endif

endmodule

FILE: tb/tsp_edge_distance_unit_test.sv
// Self-checking testbench for the TSP edge distance unit in both metrics.
`timescale 1ns / 100ps

module tsp_edge_distance_unit_test;
    import tsp_edu_pkg::*;

    localparam int COORD_W = COORD_BITS_DEF;
    localparam int LATENCY = COORD_W + 5;
    localparam logic [COORD_W-1:0] COORD_TOP = {COORD_W{1'b1}};

    class length_ledger;
        logic [OUT_BITS-1:0] pending[$];
        t_metric metric = METRIC_EUC;
        int failures = 0;

        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note_pair(logic [COORD_W-1:0] x1, logic [COORD_W-1:0] x2,
                                logic [COORD_W-1:0] y1, logic [COORD_W-1:0] y2);
            longint unsigned dx;
            longint unsigned dy;
            longint unsigned sum;
            longint unsigned r;
            dx = (x1 >= x2) ? 64'(x1) - 64'(x2) : 64'(x2) - 64'(x1);
            dy = (y1 >= y2) ? 64'(y1) - 64'(y2) : 64'(y2) - 64'(y1);
            sum = dx * dx + dy * dy;
            if (metric == METRIC_ATT) begin
                r = root_floor(sum / 10);
                if (10 * r * r < sum) r = r + 1;
            end else begin
                r = root_floor(sum);
                if (sum > r * r + r) r = r + 1;
            end
            if (r > 64'(OUT_MAX)) r = 64'(OUT_MAX);
            pending = {pending, r[OUT_BITS-1:0]};
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= 10) $display("%0t: %s", $realtime, what);
        endfunction

        function void check_length(logic [OUT_BITS-1:0] got);
            logic [OUT_BITS-1:0] want;
            if (pending.size() == 0) begin
                flag($sformatf("edge length %0d arrived with no request waiting", got));
            end else begin
                want = pending.pop_front();
                if (got !== want)
                    flag($sformatf("edge length mismatch: expected %0d, got %0d (%s)",
                                   want, got, metric.name()));
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic                i_cfg_wr_data;
    logic                i_valid;
    logic                o_stall;
    logic [COORD_W-1:0]  i_first_x;
    logic [COORD_W-1:0]  i_second_x;
    logic [COORD_W-1:0]  i_first_y;
    logic [COORD_W-1:0]  i_second_y;
    logic                o_valid;
    logic                i_stall;
    logic [OUT_BITS-1:0] o_edge_length;

    length_ledger book;
    bit tx_idle;
    bit rx_idle;

    tsp_edge_distance_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_x     (i_first_x),
        .i_second_x    (i_second_x),
        .i_first_y     (i_first_y),
        .i_second_y    (i_second_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_edge_length (o_edge_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int hold;
        i_stall <= 1'b0;
        wait (book != null);
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = rx_idle ? $urandom_range(0, 19) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            book.check_length(o_edge_length);
        end
    end

    task automatic send_pair(logic [COORD_W-1:0] x1, logic [COORD_W-1:0] x2,
                             logic [COORD_W-1:0] y1, logic [COORD_W-1:0] y2);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_first_x  <= x1;
        i_second_x <= x2;
        i_first_y  <= y1;
        i_second_y <= y2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.note_pair(x1, x2, y1, y2);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_metric(t_metric m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        book.metric = m;
    endtask

    function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] base, int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > int'(COORD_TOP)) v = int'(COORD_TOP);
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] any_coord();
        return COORD_W'($urandom_range(0, COORD_TOP));
    endfunction

    function automatic logic [COORD_W-1:0] rail();
        return $urandom_range(0, 1) ? COORD_TOP : '0;
    endfunction

    task automatic send_random_pair();
        int kind;
        logic [COORD_W-1:0] x1, x2, y1, y2;
        kind = $urandom_range(0, 9);
        x1 = any_coord();
        y1 = any_coord();
        x2 = any_coord();
        y2 = any_coord();
        if (kind == 5 || kind == 6) begin
            x2 = near(x1, 40);
            y2 = near(y1, 40);
        end else if (kind == 7) begin
            x2 = x1;
            if ($urandom_range(0, 1)) y2 = y1;
        end else if (kind == 8) begin
            x1 = rail();
            x2 = rail();
            y1 = rail();
            y2 = rail();
        end else if (kind == 9) begin
            x1 = COORD_W'($urandom_range(0, 15));
            x2 = COORD_TOP - COORD_W'($urandom_range(0, 15));
            y1 = near(y2, 3);
        end
        send_pair(x1, x2, y1, y2);
    endtask

    initial begin
        int unsigned pairs[10][4] = '{
            '{0, 0, 0, 0},
            '{32767, 32767, 32767, 32767},
            '{0, 32767, 0, 32767},
            '{32767, 0, 0, 32767},
            '{0, 32767, 5, 5},
            '{7, 7, 32767, 0},
            '{0, 1, 0, 1},
            '{0, 3, 0, 4},
            '{4, 0, 2, 0},
            '{1, 0, 3, 0}
        };
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_first_x     <= '0;
        i_second_x    <= '0;
        i_first_y     <= '0;
        i_second_y    <= '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        book = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_metric(METRIC_EUC);
        foreach (pairs[i]) send_pair(COORD_W'(pairs[i][0]), COORD_W'(pairs[i][1]),
                                     COORD_W'(pairs[i][2]), COORD_W'(pairs[i][3]));
        drain();
        write_metric(METRIC_ATT);
        foreach (pairs[i]) send_pair(COORD_W'(pairs[i][0]), COORD_W'(pairs[i][1]),
                                     COORD_W'(pairs[i][2]), COORD_W'(pairs[i][3]));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_metric(phase % 2 ? METRIC_ATT : METRIC_EUC);
            tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 3);
            for (int n = 0; n < 230; n++) begin
                send_random_pair();
                if (phase == 2 && n == 100) drain();
            end
            drain();
        end

        if (book.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
